/* sv/first_fit_heap_allocator_macros.svh */
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Property checked on every clock edge outside reset.
`define FFHA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFHA_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ffha_pkg.sv */
// Types and constants of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

  localparam int FREE_ENTRIES   = 64;
  localparam int USED_ENTRIES   = 64;
  localparam int HEAP_ADDR_BITS = 24;

  localparam int ADDR_W = HEAP_ADDR_BITS;
  localparam int LEN_W  = HEAP_ADDR_BITS + 1;
  localparam int FIDX_W = $clog2(FREE_ENTRIES);
  localparam int FCNT_W = $clog2(FREE_ENTRIES + 1);
  localparam int UIDX_W = $clog2(USED_ENTRIES);

  localparam logic [LEN_W-1:0] GROW_RESET = LEN_W'(8192);
  localparam logic [LEN_W-1:0] HDR_BYTES  = LEN_W'(8);
  localparam logic [LEN_W-1:0] ROUND_ADD  = LEN_W'(15);
  localparam logic [LEN_W-1:0] ALIGN_MASK = ~LEN_W'(7);
  localparam logic [LEN_W:0]   HEAP_LIMIT = (LEN_W + 1)'(1) << HEAP_ADDR_BITS;

  typedef enum logic [1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_FREE     = 2'd1,
    CMD_COALESCE = 2'd2,
    CMD_READ     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_NO_ENTRY  = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  len;
  } seg_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] req_bytes;
    logic [ADDR_W-1:0] user_addr;
    logic [FIDX_W-1:0] entry_index;
  } req_word_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] result_addr;
    logic [LEN_W-1:0]  seg_size;
    logic [FCNT_W-1:0] free_count;
  } rsp_word_t;

endpackage
`default_nettype wire

/* sv/ffha_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator: sequencer over the free and used RAMs.
//
//   channel   direction  handshake            payload
//   request   in         req_valid/req_stall  req_word (cmd, req_bytes, user_addr, entry_index)
//   response  out        rsp_valid/rsp_stall  rsp_word (status, result_addr, seg_size, free_count)
//   config    in         cfg_we               cfg_data (grow_bytes)
//
// One word is worked at a time; every access goes through a RAM with registered read data.
// Allocate is a free list walk plus shift-down, free a used table walk plus shift-up, and
// coalesce is sort passes until no swap, then one merge pass. The response register holds a
// finished word while the next request is taken; a stalled response holds the next finished
// word back. Reset is synchronous; the RAMs are not cleared.
`default_nettype none
`include "first_fit_heap_allocator_macros.svh"
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_word_t        req_word,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_word_t        rsp_word,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data
);

  typedef enum logic [13:0] {
    S_IDLE       = 14'b00000000000001,
    S_ALLOC_SCAN = 14'b00000000000010,
    S_SHIFT_DN   = 14'b00000000000100,
    S_GROW       = 14'b00000000001000,
    S_ALLOC_REC  = 14'b00000000010000,
    S_FREE_SCAN  = 14'b00000000100000,
    S_SHIFT_UP   = 14'b00000001000000,
    S_INS_WR     = 14'b00000010000000,
    S_SORT       = 14'b00000100000000,
    S_SORT_END   = 14'b00001000000000,
    S_MERGE      = 14'b00010000000000,
    S_MERGE_END  = 14'b00100000000000,
    S_READ       = 14'b01000000000000,
    S_DONE       = 14'b10000000000000
  } state_t;

  state_t                  state, state_next;
  logic [LEN_W-1:0]        t, t_next;
  logic [ADDR_W-1:0]       blk, blk_next;
  logic [FIDX_W-1:0]       idx, idx_next;
  logic [UIDX_W-1:0]       slot, slot_next;
  logic [FCNT_W-1:0]       free_total, free_total_next;
  logic [LEN_W-1:0]        heap_break, heap_break_next;
  logic [LEN_W-1:0]        grow_bytes, grow_bytes_next;
  logic [USED_ENTRIES-1:0] used_valid, used_valid_next;
  seg_t                    acc, acc_next;
  logic                    swapped, swapped_next;
  logic [FIDX_W-1:0]       wpos, wpos_next;
  logic [LEN_W-1:0]        ins_len, ins_len_next;
  status_t                 st, st_next;
  logic [ADDR_W-1:0]       res_addr, res_addr_next;
  logic [LEN_W-1:0]        res_size, res_size_next;
  logic                    rsp_valid_next;
  rsp_word_t               rsp_word_next;

  logic              f_we;
  logic [FIDX_W-1:0] f_waddr, f_raddr;
  seg_t              f_wdata, f_rdata;
  logic              u_we;
  logic [UIDX_W-1:0] u_waddr, u_raddr;
  seg_t              u_wdata, u_rdata;

  logic [UIDX_W-1:0] first_free;
  logic [LEN_W-1:0]  t_in;
  logic [FIDX_W-1:0] idx_p1;
  logic              last;
  logic [LEN_W-1:0]  grow_amt;
  logic [LEN_W-1:0]  seg_rem;

  ffha_ram #(.WIDTH($bits(seg_t)), .DEPTH(FREE_ENTRIES)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  ffha_ram #(.WIDTH($bits(seg_t)), .DEPTH(USED_ENTRIES)) u_used_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  always_comb begin
    first_free = '0;
    for (int i = USED_ENTRIES - 1; i >= 0; i--) begin
      if (!used_valid[i]) begin
        first_free = UIDX_W'(i);
      end
    end
  end

  assign req_stall = (state != S_IDLE);
  assign t_in      = (LEN_W'(req_word.req_bytes) + ROUND_ADD) & ALIGN_MASK;
  assign idx_p1    = idx + FIDX_W'(1);
  assign last      = ((FCNT_W'(idx) + FCNT_W'(1)) == free_total);
  assign grow_amt  = (grow_bytes > t) ? grow_bytes : t;
  assign seg_rem   = f_rdata.len - t;

  always_comb begin
    state_next      = state;
    t_next          = t;
    blk_next        = blk;
    idx_next        = idx;
    slot_next       = slot;
    free_total_next = free_total;
    heap_break_next = heap_break;
    grow_bytes_next = cfg_we ? cfg_data : grow_bytes;
    used_valid_next = used_valid;
    acc_next        = acc;
    swapped_next    = swapped;
    wpos_next       = wpos;
    ins_len_next    = ins_len;
    st_next         = st;
    res_addr_next   = res_addr;
    res_size_next   = res_size;
    rsp_valid_next  = rsp_valid && rsp_stall;
    rsp_word_next   = rsp_word;
    f_we            = 1'b0;
    f_waddr         = '0;
    f_wdata         = '0;
    f_raddr         = '0;
    u_we            = 1'b0;
    u_waddr         = slot;
    u_wdata         = '0;
    u_raddr         = '0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          t_next        = t_in;
          st_next       = ST_OK;
          res_addr_next = '0;
          res_size_next = '0;
          idx_next      = '0;
          slot_next     = '0;
          swapped_next  = 1'b0;
          if (req_word.cmd == CMD_READ) begin
            f_raddr = req_word.entry_index;
          end
          unique case (req_word.cmd)
            CMD_ALLOC: begin
              if (&used_valid) begin
                st_next    = ST_FULL;
                state_next = S_DONE;
              end else begin
                slot_next  = first_free;
                state_next = (free_total == '0) ? S_GROW : S_ALLOC_SCAN;
              end
            end
            CMD_FREE: begin
              if (LEN_W'(req_word.user_addr) < HDR_BYTES) begin
                st_next    = ST_UNKNOWN;
                state_next = S_DONE;
              end else begin
                blk_next   = req_word.user_addr - ADDR_W'(HDR_BYTES);
                state_next = S_FREE_SCAN;
              end
            end
            CMD_COALESCE: begin
              state_next = (free_total < FCNT_W'(2)) ? S_DONE : S_SORT;
            end
            CMD_READ: begin
              if (FCNT_W'(req_word.entry_index) < free_total) begin
                state_next = S_READ;
              end else begin
                st_next    = ST_NO_ENTRY;
                state_next = S_DONE;
              end
            end
          endcase
        end
      end

      S_ALLOC_SCAN: begin
        if (f_rdata.len >= t) begin
          if ({1'b0, f_rdata.len} >= ({1'b0, t} + {1'b0, HDR_BYTES})) begin
            // Split: the block comes off the top of the segment.
            f_we       = 1'b1;
            f_waddr    = idx;
            f_wdata    = '{base: f_rdata.base, len: seg_rem};
            blk_next   = ADDR_W'(LEN_W'(f_rdata.base) + seg_rem);
            state_next = S_ALLOC_REC;
          end else begin
            blk_next = f_rdata.base;
            if (last) begin
              free_total_next = free_total - FCNT_W'(1);
              state_next      = S_ALLOC_REC;
            end else begin
              f_raddr    = idx_p1;
              idx_next   = idx_p1;
              state_next = S_SHIFT_DN;
            end
          end
        end else if (last) begin
          state_next = S_GROW;
        end else begin
          f_raddr  = idx_p1;
          idx_next = idx_p1;
        end
      end

      S_SHIFT_DN: begin
        f_we    = 1'b1;
        f_waddr = idx - FIDX_W'(1);
        f_wdata = f_rdata;
        if (last) begin
          free_total_next = free_total - FCNT_W'(1);
          state_next      = S_ALLOC_REC;
        end else begin
          f_raddr  = idx_p1;
          idx_next = idx_p1;
        end
      end

      S_GROW: begin
        if (free_total >= FCNT_W'(FREE_ENTRIES)) begin
          st_next    = ST_FULL;
          state_next = S_DONE;
        end else if (({1'b0, heap_break} + {1'b0, grow_amt}) > HEAP_LIMIT) begin
          st_next    = ST_EXHAUSTED;
          state_next = S_DONE;
        end else begin
          heap_break_next = heap_break + grow_amt;
          if ({1'b0, grow_amt} >= ({1'b0, t} + {1'b0, HDR_BYTES})) begin
            f_we            = 1'b1;
            f_waddr         = FIDX_W'(free_total);
            f_wdata         = '{base: ADDR_W'(heap_break), len: grow_amt - t};
            free_total_next = free_total + FCNT_W'(1);
            blk_next        = ADDR_W'(heap_break + grow_amt - t);
          end else begin
            blk_next = ADDR_W'(heap_break);
          end
          state_next = S_ALLOC_REC;
        end
      end

      S_ALLOC_REC: begin
        u_we                  = 1'b1;
        u_waddr               = slot;
        u_wdata               = '{base: blk, len: t};
        used_valid_next[slot] = 1'b1;
        res_addr_next         = blk + ADDR_W'(HDR_BYTES);
        state_next            = S_DONE;
      end

      S_FREE_SCAN: begin
        if (used_valid[slot] && (u_rdata.base == blk)) begin
          if (free_total >= FCNT_W'(FREE_ENTRIES)) begin
            st_next    = ST_FULL;
            state_next = S_DONE;
          end else begin
            used_valid_next[slot] = 1'b0;
            ins_len_next          = u_rdata.len;
            if (free_total < FCNT_W'(2)) begin
              f_we            = 1'b1;
              f_waddr         = (free_total == '0) ? FIDX_W'(0) : FIDX_W'(1);
              f_wdata         = '{base: blk, len: u_rdata.len};
              free_total_next = free_total + FCNT_W'(1);
              state_next      = S_DONE;
            end else begin
              // Open position one by moving the tail up, last entry first.
              f_raddr    = FIDX_W'(free_total - FCNT_W'(1));
              idx_next   = FIDX_W'(free_total - FCNT_W'(1));
              state_next = S_SHIFT_UP;
            end
          end
        end else if (slot == UIDX_W'(USED_ENTRIES - 1)) begin
          st_next    = ST_UNKNOWN;
          state_next = S_DONE;
        end else begin
          u_raddr   = slot + UIDX_W'(1);
          slot_next = slot + UIDX_W'(1);
        end
      end

      S_SHIFT_UP: begin
        f_we    = 1'b1;
        f_waddr = idx_p1;
        f_wdata = f_rdata;
        if (idx == FIDX_W'(1)) begin
          state_next = S_INS_WR;
        end else begin
          f_raddr  = idx - FIDX_W'(1);
          idx_next = idx - FIDX_W'(1);
        end
      end

      S_INS_WR: begin
        f_we            = 1'b1;
        f_waddr         = FIDX_W'(1);
        f_wdata         = '{base: blk, len: ins_len};
        free_total_next = free_total + FCNT_W'(1);
        state_next      = S_DONE;
      end

      S_SORT: begin
        // One bubble pass: acc carries the highest base seen so far.
        if (idx == '0) begin
          acc_next = f_rdata;
        end else if (f_rdata.base < acc.base) begin
          f_we         = 1'b1;
          f_waddr      = idx - FIDX_W'(1);
          f_wdata      = f_rdata;
          swapped_next = 1'b1;
        end else begin
          f_we     = 1'b1;
          f_waddr  = idx - FIDX_W'(1);
          f_wdata  = acc;
          acc_next = f_rdata;
        end
        if (last) begin
          state_next = S_SORT_END;
        end else begin
          f_raddr  = idx_p1;
          idx_next = idx_p1;
        end
      end

      S_SORT_END: begin
        f_we         = 1'b1;
        f_waddr      = FIDX_W'(free_total - FCNT_W'(1));
        f_wdata      = acc;
        idx_next     = '0;
        swapped_next = 1'b0;
        state_next   = swapped ? S_SORT : S_MERGE;
      end

      S_MERGE: begin
        if (idx == '0) begin
          acc_next  = f_rdata;
          wpos_next = '0;
        end else if ((LEN_W'(acc.base) + acc.len) == LEN_W'(f_rdata.base)) begin
          acc_next.len = acc.len + f_rdata.len;
        end else begin
          f_we      = 1'b1;
          f_waddr   = wpos;
          f_wdata   = acc;
          wpos_next = wpos + FIDX_W'(1);
          acc_next  = f_rdata;
        end
        if (last) begin
          state_next = S_MERGE_END;
        end else begin
          f_raddr  = idx_p1;
          idx_next = idx_p1;
        end
      end

      S_MERGE_END: begin
        f_we            = 1'b1;
        f_waddr         = wpos;
        f_wdata         = acc;
        free_total_next = FCNT_W'(wpos) + FCNT_W'(1);
        state_next      = S_DONE;
      end

      S_READ: begin
        res_addr_next = f_rdata.base;
        res_size_next = f_rdata.len;
        state_next    = S_DONE;
      end

      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_word_next = '{status: st, result_addr: res_addr, seg_size: res_size,
                            free_count: free_total};
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_total <= '0;
      heap_break <= '0;
      grow_bytes <= GROW_RESET;
      used_valid <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      free_total <= free_total_next;
      heap_break <= heap_break_next;
      grow_bytes <= grow_bytes_next;
      used_valid <= used_valid_next;
      rsp_valid  <= rsp_valid_next;
    end
    t        <= t_next;
    blk      <= blk_next;
    idx      <= idx_next;
    slot     <= slot_next;
    acc      <= acc_next;
    swapped  <= swapped_next;
    wpos     <= wpos_next;
    ins_len  <= ins_len_next;
    st       <= st_next;
    res_addr <= res_addr_next;
    res_size <= res_size_next;
    rsp_word <= rsp_word_next;
  end

  `FFHA_CHECK(a_free_total_max, free_total <= FCNT_W'(FREE_ENTRIES), "free list count overflow")
  `FFHA_CHECK(a_heap_limit, heap_break <= HEAP_LIMIT, "heap break beyond address space")
  `FFHA_CHECK(a_free_wr_range, f_we |-> (FCNT_W'(f_waddr) <= free_total), "free write past list end")
  `FFHA_CHECK(a_used_wr_fresh, u_we |-> !used_valid[u_waddr], "used record overwrites live entry")
  `FFHA_NEXT(a_accept_busy, req_valid && !req_stall, state != S_IDLE, "accepted word left idle")

endmodule
`default_nettype wire
